// ----- sv/sgm_pkg.sv -----
package sgm_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int FRAME_DIM_RST  = 1024;

  localparam int PIX_W  = 8;
  localparam int FW_W   = 11;
  localparam int FH_W   = 13;
  localparam int MAG_W  = 11;
  localparam int ROWO_W = 12;
  localparam int COLO_W = 10;
  localparam int GR_W   = 11;
  localparam int SQ_W   = 22;
  localparam int RM_W   = 13;
  localparam int IT_W   = 4;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = 2;

  localparam logic ADDR_WIDTH_REG  = 1'b0;
  localparam logic ADDR_HEIGHT_REG = 1'b1;

  localparam logic [1:0] SLOT_UP_LEFT  = 2'd0;
  localparam logic [1:0] SLOT_UP_EDGE  = 2'd1;
  localparam logic [1:0] SLOT_CUR_LEFT = 2'd2;
  localparam logic [1:0] SLOT_CUR_EDGE = 2'd3;

  localparam logic [IT_W-1:0] ROOT_LAST = IT_W'(MAG_W - 1);

  typedef logic [2:0][PIX_W-1:0] col_t;
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [FW_W-1:0] width;
    logic [FH_W-1:0] height;
    logic            restart;
  } cfg_t;

  typedef struct packed {
    col_t              lcol;
    col_t              mcol;
    col_t              rcol;
    logic [ROWO_W-1:0] row;
    logic [COLO_W-1:0] col;
    logic              last;
  } job_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_LOAD,
    F_EMIT
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_GRAD,
    B_SQ,
    B_ROOT,
    B_DONE
  } back_state_t;

  function automatic logic signed [GR_W-1:0] sext(input logic [PIX_W-1:0] p);
    return signed'({{(GR_W - PIX_W){1'b0}}, p});
  endfunction

endpackage

// ----- sv/sobel_gradient_magnitude.sv -----
// 3x3 sobel gradient magnitude over a raster pixel stream
// input: one pixel per request on in_valid/in_stall, raster order, frame of
//   frame_width by frame_height set through the register port (0x0 width,
//   0x4 height); a register write restarts the frame at row 0, column 0
// output: out_magnitude = floor(sqrt(gx^2 + gy^2)) tagged with out_row and
//   out_col, raster order; out_frame_last marks the last pixel of the frame
// a pixel completes up to four results (right column, last row); edges use
//   the nearest pixel inside the frame
// front: accept with line store read, line store update, then four result
//   slots, limited by the single-port line store and the slot sequencer
// back: one result at a time, gradient, square and 11-step digit-by-digit
//   square root; a 4-entry queue between them lets each side stall on its own
// the front takes a new pixel only after the result slots of the last one
// reset: counters and window cleared, width and height back to 1024 (or the
//   maximum); line stores are not cleared and need no clearing pass
// a stalled result holds in the output register while the back end starts
//   the next one; in_stall is high while the front loads the window and
//   steps through the result slots, and while a result waits for queue room
module sobel_gradient_magnitude #(
  parameter int MAX_WIDTH  = sgm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sgm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sgm_pkg::PIX_W-1:0]   in_pixel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sgm_pkg::MAG_W-1:0]   out_magnitude,
  output logic [sgm_pkg::ROWO_W-1:0]  out_row,
  output logic [sgm_pkg::COLO_W-1:0]  out_col,
  output logic                        out_frame_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sgm_pkg::ADDR_W-1:0]  paddr,
  input  logic [sgm_pkg::DATA_W-1:0]  pwdata,
  output logic [sgm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int FW = sgm_pkg::FW_W;
  localparam int FH = sgm_pkg::FH_W;
  localparam logic [FW-1:0] FW_RST =
    FW'((MAX_WIDTH < sgm_pkg::FRAME_DIM_RST) ? MAX_WIDTH : sgm_pkg::FRAME_DIM_RST);
  localparam logic [FH-1:0] FH_RST =
    FH'((MAX_HEIGHT < sgm_pkg::FRAME_DIM_RST) ? MAX_HEIGHT : sgm_pkg::FRAME_DIM_RST);

  logic [FW-1:0] fw_r, fw_set, wv;
  logic [FH-1:0] fh_r, fh_set, hv;
  logic          wr;
  sgm_pkg::cfg_t    cfg;
  sgm_pkg::q_stat_t q_stat;
  sgm_pkg::job_t    push_job, head;
  logic             push, pop;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign wv     = pwdata[FW-1:0];
  assign hv     = pwdata[FH-1:0];

  always_comb begin
    if (wv == '0) begin
      fw_set = FW'(1);
    end else if (int'(wv) > MAX_WIDTH) begin
      fw_set = FW'(MAX_WIDTH);
    end else begin
      fw_set = wv;
    end
    if (hv == '0) begin
      fh_set = FH'(1);
    end else if (int'(hv) > MAX_HEIGHT) begin
      fh_set = FH'(MAX_HEIGHT);
    end else begin
      fh_set = hv;
    end
  end

  always_comb begin
    unique case (paddr[2])
      sgm_pkg::ADDR_WIDTH_REG:  prdata = sgm_pkg::DATA_W'(fw_r);
      sgm_pkg::ADDR_HEIGHT_REG: prdata = sgm_pkg::DATA_W'(fh_r);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_RST;
      fh_r <= FH_RST;
    end else if (wr) begin
      if (paddr[2] == sgm_pkg::ADDR_HEIGHT_REG) begin
        fh_r <= fh_set;
      end else begin
        fw_r <= fw_set;
      end
    end
  end

  assign cfg.width   = fw_r;
  assign cfg.height  = fh_r;
  assign cfg.restart = wr;

  sgm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_pixel (in_pixel),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .push     (push),
    .job      (push_job)
  );

  sgm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  sgm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_magnitude  (out_magnitude),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last)
  );

endmodule

// ----- sv/sgm_front.sv -----
module sgm_front #(
  parameter int MAX_WIDTH  = sgm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sgm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sgm_pkg::PIX_W-1:0]  in_pixel,
  input  sgm_pkg::cfg_t              cfg,
  input  sgm_pkg::q_stat_t           q_stat,
  output logic                       push,
  output sgm_pkg::job_t              job
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CW = (COL_W >= sgm_pkg::FW_W) ? COL_W + 1 : sgm_pkg::FW_W + 1;
  localparam int RW = (ROW_W >= sgm_pkg::FH_W) ? ROW_W + 1 : sgm_pkg::FH_W + 1;
  localparam int PW = sgm_pkg::PIX_W;

  sgm_pkg::front_state_t st_r, st_nxt;
  logic [COL_W-1:0]  c_r;
  logic [ROW_W-1:0]  r_r;
  logic [COL_W-1:0]  pc_r;
  logic [ROW_W-1:0]  pr_r;
  logic [PW-1:0]     px_r;
  logic [2*PW-1:0]   rd_r;
  logic              lcol_r, lrow_r;
  logic [1:0]        slot_r;
  sgm_pkg::win_t     win_r;
  logic [2*PW-1:0]   mem [MAX_WIDTH];

  logic accept, last_col, last_row, slot_ok, advance;
  logic lo_half, even, c_ge1, c_ge2, r_ge1, r_ge2;
  sgm_pkg::col_t lsrc, msrc;

  function automatic sgm_pkg::col_t pick_rows(input sgm_pkg::col_t c, input logic up,
                                              input logic deep);
    sgm_pkg::col_t o;
    o[2] = c[2];
    o[1] = up ? c[1] : c[2];
    if (up) begin
      o[0] = deep ? c[0] : c[1];
    end else begin
      o[0] = deep ? c[1] : c[2];
    end
    return o;
  endfunction

  assign accept   = (st_r == sgm_pkg::F_IDLE) && in_valid;
  assign last_col = (CW'(c_r) + CW'(1)) >= CW'(cfg.width);
  assign last_row = (RW'(r_r) + RW'(1)) >= RW'(cfg.height);

  assign c_ge1 = (pc_r != '0);
  assign c_ge2 = (pc_r > COL_W'(1));
  assign r_ge1 = (pr_r != '0);
  assign r_ge2 = (pr_r > ROW_W'(1));

  always_comb begin
    unique case (st_r)
      sgm_pkg::F_IDLE: st_nxt = in_valid ? sgm_pkg::F_LOAD : sgm_pkg::F_IDLE;
      sgm_pkg::F_LOAD: st_nxt = sgm_pkg::F_EMIT;
      sgm_pkg::F_EMIT: begin
        st_nxt = (advance && slot_r == sgm_pkg::SLOT_CUR_EDGE) ? sgm_pkg::F_IDLE
                                                                : sgm_pkg::F_EMIT;
      end
      default: st_nxt = sgm_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    case (slot_r)
      sgm_pkg::SLOT_UP_LEFT:  slot_ok = r_ge1 && c_ge1;
      sgm_pkg::SLOT_UP_EDGE:  slot_ok = r_ge1 && lcol_r;
      sgm_pkg::SLOT_CUR_LEFT: slot_ok = lrow_r && c_ge1;
      default:                slot_ok = lrow_r && lcol_r;
    endcase
    lo_half = (slot_r == sgm_pkg::SLOT_UP_LEFT) || (slot_r == sgm_pkg::SLOT_UP_EDGE);
    even    = (slot_r == sgm_pkg::SLOT_UP_LEFT) || (slot_r == sgm_pkg::SLOT_CUR_LEFT);
    if (even) begin
      lsrc = c_ge2 ? win_r[0] : win_r[1];
      msrc = win_r[1];
    end else begin
      lsrc = c_ge1 ? win_r[1] : win_r[2];
      msrc = win_r[2];
    end
  end

  always_comb begin
    in_stall = (st_r != sgm_pkg::F_IDLE);
    advance  = (st_r == sgm_pkg::F_EMIT) && (!slot_ok || !q_stat.full);
    push     = (st_r == sgm_pkg::F_EMIT) && slot_ok && !q_stat.full;
    job.lcol = pick_rows(lsrc, lo_half, lo_half ? r_ge2 : r_ge1);
    job.mcol = pick_rows(msrc, lo_half, lo_half ? r_ge2 : r_ge1);
    job.rcol = pick_rows(win_r[2], lo_half, lo_half ? r_ge2 : r_ge1);
    job.row  = lo_half ? sgm_pkg::ROWO_W'(pr_r - ROW_W'(1)) : sgm_pkg::ROWO_W'(pr_r);
    job.col  = even ? sgm_pkg::COLO_W'(pc_r - COL_W'(1)) : sgm_pkg::COLO_W'(pc_r);
    job.last = (slot_r == sgm_pkg::SLOT_CUR_EDGE);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= mem[c_r];
    end
    if (st_r == sgm_pkg::F_LOAD) begin
      mem[pc_r] <= {rd_r[PW-1:0], px_r};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r   <= in_pixel;
      pc_r   <= c_r;
      pr_r   <= r_r;
      lcol_r <= last_col;
      lrow_r <= last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= sgm_pkg::F_IDLE;
      c_r    <= '0;
      r_r    <= '0;
      slot_r <= sgm_pkg::SLOT_UP_LEFT;
      win_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg.restart) begin
        c_r   <= '0;
        r_r   <= '0;
        win_r <= '0;
      end else begin
        if (accept) begin
          if (last_col) begin
            c_r <= '0;
            r_r <= last_row ? '0 : r_r + ROW_W'(1);
          end else begin
            c_r <= c_r + COL_W'(1);
          end
        end
        if (st_r == sgm_pkg::F_LOAD) begin
          win_r[0] <= win_r[1];
          win_r[1] <= win_r[2];
          win_r[2] <= {px_r, rd_r[PW-1:0], rd_r[2*PW-1:PW]};
        end
      end
      if (st_r == sgm_pkg::F_LOAD) begin
        slot_r <= sgm_pkg::SLOT_UP_LEFT;
      end else if (advance) begin
        slot_r <= slot_r + 2'd1;
      end
    end
  end

endmodule

// ----- sv/sgm_queue.sv -----
module sgm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sgm_pkg::job_t    push_job,
  input  logic             pop,
  output sgm_pkg::job_t    head,
  output sgm_pkg::q_stat_t stat
);

  sgm_pkg::job_t q_r [sgm_pkg::QUEUE_DEPTH];
  logic [sgm_pkg::QP_W-1:0] wp_r, rp_r;
  logic [sgm_pkg::QP_W:0]   cnt_r;

  assign head       = q_r[rp_r];
  assign stat.full  = (cnt_r == (sgm_pkg::QP_W + 1)'(sgm_pkg::QUEUE_DEPTH));
  assign stat.valid = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + sgm_pkg::QP_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + sgm_pkg::QP_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (sgm_pkg::QP_W + 1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (sgm_pkg::QP_W + 1)'(1);
      end
    end
  end

endmodule

// ----- sv/sgm_back.sv -----
module sgm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sgm_pkg::q_stat_t            q_stat,
  input  sgm_pkg::job_t               head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sgm_pkg::MAG_W-1:0]   out_magnitude,
  output logic [sgm_pkg::ROWO_W-1:0]  out_row,
  output logic [sgm_pkg::COLO_W-1:0]  out_col,
  output logic                        out_frame_last
);

  localparam int GR2 = 2 * sgm_pkg::GR_W;
  localparam int RS  = sgm_pkg::RM_W + 2;

  sgm_pkg::back_state_t st_r, st_nxt;
  sgm_pkg::job_t job_r;
  logic signed [sgm_pkg::GR_W-1:0] gx_r, gy_r, gx_nxt, gy_nxt;
  logic signed [GR2-1:0]           gxx, gyy;
  logic [sgm_pkg::SQ_W-1:0]        val_r;
  logic [sgm_pkg::RM_W-1:0]        rem_r;
  logic [sgm_pkg::MAG_W-1:0]       root_r;
  logic [sgm_pkg::IT_W-1:0]        it_r;
  logic [RS-1:0]                   rem_sh, trial;
  logic                            load_out, out_valid_r;

  always_comb begin
    gx_nxt = (sgm_pkg::sext(job_r.lcol[0]) - sgm_pkg::sext(job_r.rcol[0]))
           + ((sgm_pkg::sext(job_r.lcol[1]) - sgm_pkg::sext(job_r.rcol[1])) <<< 1)
           + (sgm_pkg::sext(job_r.lcol[2]) - sgm_pkg::sext(job_r.rcol[2]));
    gy_nxt = (sgm_pkg::sext(job_r.lcol[0]) - sgm_pkg::sext(job_r.lcol[2]))
           + ((sgm_pkg::sext(job_r.mcol[0]) - sgm_pkg::sext(job_r.mcol[2])) <<< 1)
           + (sgm_pkg::sext(job_r.rcol[0]) - sgm_pkg::sext(job_r.rcol[2]));
  end

  assign gxx    = GR2'(gx_r) * GR2'(gx_r);
  assign gyy    = GR2'(gy_r) * GR2'(gy_r);
  assign rem_sh = {rem_r, val_r[sgm_pkg::SQ_W-1 -: 2]};
  assign trial  = {{(RS - sgm_pkg::MAG_W - 2){1'b0}}, root_r, 2'b01};

  always_comb begin
    unique case (st_r)
      sgm_pkg::B_IDLE: st_nxt = q_stat.valid ? sgm_pkg::B_GRAD : sgm_pkg::B_IDLE;
      sgm_pkg::B_GRAD: st_nxt = sgm_pkg::B_SQ;
      sgm_pkg::B_SQ:   st_nxt = sgm_pkg::B_ROOT;
      sgm_pkg::B_ROOT: begin
        st_nxt = (it_r == sgm_pkg::ROOT_LAST) ? sgm_pkg::B_DONE : sgm_pkg::B_ROOT;
      end
      sgm_pkg::B_DONE: begin
        st_nxt = (!out_valid_r || !out_stall) ? sgm_pkg::B_IDLE : sgm_pkg::B_DONE;
      end
      default: st_nxt = sgm_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop      = (st_r == sgm_pkg::B_IDLE) && q_stat.valid;
    load_out = (st_r == sgm_pkg::B_DONE) && (!out_valid_r || !out_stall);
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head;
    end
    if (st_r == sgm_pkg::B_GRAD) begin
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
    end
    if (st_r == sgm_pkg::B_SQ) begin
      val_r  <= sgm_pkg::SQ_W'(unsigned'(gxx)) + sgm_pkg::SQ_W'(unsigned'(gyy));
      rem_r  <= '0;
      root_r <= '0;
      it_r   <= '0;
    end
    if (st_r == sgm_pkg::B_ROOT) begin
      val_r <= val_r << 2;
      it_r  <= it_r + sgm_pkg::IT_W'(1);
      if (rem_sh >= trial) begin
        rem_r  <= sgm_pkg::RM_W'(rem_sh - trial);
        root_r <= {root_r[sgm_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_r  <= sgm_pkg::RM_W'(rem_sh);
        root_r <= {root_r[sgm_pkg::MAG_W-2:0], 1'b0};
      end
    end
    if (load_out) begin
      out_magnitude  <= root_r;
      out_row        <= job_r.row;
      out_col        <= job_r.col;
      out_frame_last <= job_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= sgm_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/sgm_checker.sv -----
module sgm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [sgm_pkg::MAG_W-1:0]   out_magnitude,
  input logic [sgm_pkg::ROWO_W-1:0]  out_row,
  input logic [sgm_pkg::COLO_W-1:0]  out_col,
  input logic                        out_frame_last
);

  localparam logic [sgm_pkg::MAG_W-1:0] MAG_MAX = sgm_pkg::MAG_W'(1442);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_magnitude) && $stable(out_row)
      && $stable(out_col) && $stable(out_frame_last))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channels not idle after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("front took a second pixel while loading the window");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_magnitude <= MAG_MAX)
    else $error("magnitude out of range");

endmodule

bind sobel_gradient_magnitude sgm_checker u_sgm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_magnitude  (out_magnitude),
  .out_row        (out_row),
  .out_col        (out_col),
  .out_frame_last (out_frame_last)
);

// ----- test/tb_sobel_gradient_magnitude.sv -----
module tb_sobel_gradient_magnitude;

  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned QUIET_CYCLES    = 64;
  localparam int unsigned IDLE_LIMIT      = 3000;

  typedef struct packed {
    logic [sgm_pkg::MAG_W-1:0]  magnitude;
    logic [sgm_pkg::ROWO_W-1:0] row;
    logic [sgm_pkg::COLO_W-1:0] col;
    logic                       last;
  } grad_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [sgm_pkg::PIX_W-1:0]  in_pixel = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b1;
  logic [sgm_pkg::MAG_W-1:0]  out_magnitude;
  logic [sgm_pkg::ROWO_W-1:0] out_row;
  logic [sgm_pkg::COLO_W-1:0] out_col;
  logic                       out_frame_last;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [sgm_pkg::ADDR_W-1:0] paddr = '0;
  logic [sgm_pkg::DATA_W-1:0] pwdata = '0;
  logic [sgm_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  // predicted state of the filter
  logic [sgm_pkg::PIX_W-1:0] row_above [sgm_pkg::MAX_WIDTH_DEF];
  logic [sgm_pkg::PIX_W-1:0] row_two_above [sgm_pkg::MAX_WIDTH_DEF];
  logic [sgm_pkg::PIX_W-1:0] win [3][3];
  int unsigned               next_row;
  int unsigned               next_col;
  int unsigned               frame_w = sgm_pkg::FRAME_DIM_RST;
  int unsigned               frame_h = sgm_pkg::FRAME_DIM_RST;

  grad_result_t pending_grads[$];
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles = 0;
  bit           send_burst = 1'b0;
  bit           recv_burst = 1'b0;
  bit           hold_off_req = 1'b0;

  sobel_gradient_magnitude u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_magnitude  (out_magnitude),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #10 clk = ~clk;

  function automatic void flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void restart_frame();
    next_row = 0;
    next_col = 0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        win[k][j] = '0;
      end
    end
  endfunction

  function automatic void apply_frame_reg(logic reg_idx, logic [sgm_pkg::DATA_W-1:0] data);
    int unsigned v;
    if (reg_idx == sgm_pkg::ADDR_WIDTH_REG) begin
      v = data[sgm_pkg::FW_W-1:0];
      if (v == 0) v = 1;
      if (v > sgm_pkg::MAX_WIDTH_DEF) v = sgm_pkg::MAX_WIDTH_DEF;
      frame_w = v;
    end else begin
      v = data[sgm_pkg::FH_W-1:0];
      if (v == 0) v = 1;
      if (v > sgm_pkg::MAX_HEIGHT_DEF) v = sgm_pkg::MAX_HEIGHT_DEF;
      frame_h = v;
    end
    restart_frame();
  endfunction

  // window indexes: column 0 oldest, row 0 top
  function automatic int unsigned window_magnitude(int cl, int cm, int cr,
                                                   int rt, int rm, int rb);
    int          gx;
    int          gy;
    int unsigned sq;
    int unsigned root;
    gx = (int'(win[cl][rt]) - int'(win[cr][rt]))
       + 2 * (int'(win[cl][rm]) - int'(win[cr][rm]))
       + (int'(win[cl][rb]) - int'(win[cr][rb]));
    gy = (int'(win[cl][rt]) - int'(win[cl][rb]))
       + 2 * (int'(win[cm][rt]) - int'(win[cm][rb]))
       + (int'(win[cr][rt]) - int'(win[cr][rb]));
    sq = gx * gx + gy * gy;
    root = int'($floor($sqrt(real'(sq))));
    while (root * root > sq) root--;
    while ((root + 1) * (root + 1) <= sq) root++;
    return root;
  endfunction

  function automatic void push_grad(int unsigned mag, int unsigned row,
                                    int unsigned col, logic last);
    grad_result_t g;
    g.magnitude = sgm_pkg::MAG_W'(mag);
    g.row       = sgm_pkg::ROWO_W'(row);
    g.col       = sgm_pkg::COLO_W'(col);
    g.last      = last;
    pending_grads.insert(pending_grads.size(), g);
  endfunction

  function automatic void predict_pixel(logic [sgm_pkg::PIX_W-1:0] pix);
    int unsigned r;
    int unsigned c;
    bit          last_col;
    bit          last_row;
    int          rt;
    r = next_row;
    c = next_col;
    last_col = (c + 1 >= frame_w);
    last_row = (r + 1 >= frame_h);
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 3; j++) begin
        win[k][j] = win[k+1][j];
      end
    end
    win[2][0] = row_two_above[c];
    win[2][1] = row_above[c];
    win[2][2] = pix;
    row_two_above[c] = row_above[c];
    row_above[c] = pix;
    if (r >= 1) begin
      rt = (r >= 2) ? 0 : 1;
      if (c >= 1) push_grad(window_magnitude((c >= 2) ? 0 : 1, 1, 2, rt, 1, 2),
                            r - 1, c - 1, 1'b0);
      if (last_col) push_grad(window_magnitude((c >= 1) ? 1 : 2, 2, 2, rt, 1, 2),
                              r - 1, c, 1'b0);
    end
    if (last_row) begin
      rt = (r >= 1) ? 1 : 2;
      if (c >= 1) push_grad(window_magnitude((c >= 2) ? 0 : 1, 1, 2, rt, 2, 2),
                            r, c - 1, 1'b0);
      if (last_col) push_grad(window_magnitude((c >= 1) ? 1 : 2, 2, 2, rt, 2, 2),
                              r, c, 1'b1);
    end
    if (last_col) begin
      next_col = 0;
      next_row = last_row ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
  endfunction

  function automatic logic [sgm_pkg::PIX_W-1:0] draw_pixel();
    int unsigned pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return sgm_pkg::PIX_W'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(input logic [sgm_pkg::PIX_W-1:0] pix);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    do @(posedge clk); while (in_stall);
    predict_pixel(pix);
  endtask

  task automatic wait_drained(input int unsigned settle);
    in_valid <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_idx, input int unsigned value);
    logic [sgm_pkg::DATA_W-1:0] data;
    data = $urandom();
    if (reg_idx == sgm_pkg::ADDR_WIDTH_REG) begin
      data[sgm_pkg::FW_W-1:0] = value[sgm_pkg::FW_W-1:0];
    end else begin
      data[sgm_pkg::FH_W-1:0] = value[sgm_pkg::FH_W-1:0];
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_frame_reg(reg_idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input int unsigned width, input int unsigned height);
    wait_drained(QUIET_CYCLES);
    write_reg(sgm_pkg::ADDR_WIDTH_REG, width);
    write_reg(sgm_pkg::ADDR_HEIGHT_REG, height);
  endtask

  // reset size is 1024 by 1024, so row 0 gives nothing
  task automatic test_reset_size();
    send_pixel(8'h00);
    send_pixel(8'hFF);
  endtask

  task automatic test_tiny_frames();
    set_frame(1, 1);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    // zero reads as one
    set_frame(0, 0);
    send_pixel(8'h5A);
    set_frame(1, 3);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    set_frame(3, 1);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'hFF);
  endtask

  task automatic test_peak_gradient();
    logic [sgm_pkg::PIX_W-1:0] corner [9];
    corner = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    set_frame(3, 3);
    for (int i = 0; i < 9; i++) send_pixel(corner[i]);
  endtask

  // oversized values saturate to the maximum frame size
  task automatic test_size_limits();
    set_frame(2047, 0);
    repeat (5) send_pixel(draw_pixel());
    set_frame(1, 8191);
    repeat (4) send_pixel(draw_pixel());
  endtask

  task automatic test_backpressure();
    set_frame(5, 12);
    send_burst   = 1'b1;
    hold_off_req = 1'b1;
    repeat (30) send_pixel(draw_pixel());
    // sender pause mid frame until every result is back
    wait_drained(0);
    send_burst = 1'b0;
    repeat (30) send_pixel(draw_pixel());
  endtask

  task automatic test_random_frames(input int unsigned target);
    int unsigned sent;
    int unsigned kind;
    int unsigned w;
    int unsigned h;
    int unsigned npix;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 5);
      end else if (kind < 9) begin
        w = $urandom_range(7, 24);
        h = $urandom_range(1, 3);
      end else begin
        w = $urandom_range(25, 1024);
        h = $urandom_range(0, 1) ? 1 : $urandom_range(2, 4096);
      end
      set_frame(w, h);
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      npix = w * h * $urandom_range(1, 2);
      if (kind == 9 && npix > 40) npix = 40;
      // cut frame, restarted by the next register write
      if ($urandom_range(0, 4) == 0) npix = $urandom_range(1, npix);
      repeat (npix) send_pixel(draw_pixel());
      sent += npix;
    end
    send_burst = 1'b0;
    recv_burst = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < sgm_pkg::MAX_WIDTH_DEF; i++) begin
      row_above[i] = '0;
      row_two_above[i] = '0;
    end
    restart_frame();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_size();
    test_tiny_frames();
    test_peak_gradient();
    test_size_limits();
    test_backpressure();
    test_random_frames(180);
    wait_drained(QUIET_CYCLES);
    if (mismatch_count == 0 && pending_grads.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side stall
  initial begin
    int unsigned pause;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      pause = recv_burst ? 0 : $urandom_range(0, 15);
      if (pause != 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_results
    grad_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_grads.size() == 0) begin
        flag_error($sformatf("unexpected result: mag %0d row %0d col %0d last %0b",
                             out_magnitude, out_row, out_col, out_frame_last));
      end else begin
        want = pending_grads.pop_front();
        if (out_magnitude !== want.magnitude || out_row !== want.row ||
            out_col !== want.col || out_frame_last !== want.last) begin
          flag_error($sformatf(
            "mismatch: expected mag %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
            want.magnitude, want.row, want.col, want.last,
            out_magnitude, out_row, out_col, out_frame_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
